// File: rtl/bpn_pkg.sv
// bpn_pkg: shared types and constants of the batch peak normalizer
// no dependencies; used by every rtl file of the block
`default_nettype none

package bpn_pkg;

    // sample and result widths
    localparam int DATA_W   = 32;
    localparam int MAG_W    = 31;
    localparam int FRAC_W   = 16;
    localparam int RATIO_W  = FRAC_W + 1;
    localparam int OUT_W    = 24;

    // batch length counter, wide enough for the largest batch of 64
    localparam int CNT_W    = 7;

    // batches that may be stored or in service at once (one per bank)
    localparam logic [1:0] MAX_PENDING = 2'd2;

    localparam logic [MAG_W-1:0]   MAG_MAX     = {MAG_W{1'b1}};
    localparam logic [RATIO_W-1:0] LIMIT_RESET = RATIO_W'(65535);

    // one finished batch handed from the front to the back
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic [MAG_W-1:0] peak;
    } desc_t;

endpackage

`default_nettype wire

// File: rtl/batch_peak_normalizer_unit.sv
// A batch's first ratio passes the queue, the batch load, the store read, the divider's
// 17 stages and the output register. Throughput: one item per cycle in and one ratio
// per cycle out while m_axis_tready is high; the back loads each batch before reading
// its items; the input stalls while both store banks wait.
// Reset (rst_n, async, low): peaks, counters, queue and pipeline valids clear;
// clamp_limit returns to 65535; the magnitude store is not cleared.
`default_nettype none

module batch_peak_normalizer_unit #(
    parameter int MAX_BATCH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // s_axis_tdata: velocity[31:0]
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [bpn_pkg::DATA_W-1:0]    s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    // m_axis_tdata: ratio[16:0], zeros[23:17]
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [bpn_pkg::OUT_W-1:0]          m_axis_tdata,
    output logic                               m_axis_tlast,
    // clamp_limit write
    input  wire logic                          cfg_we,
    input  wire logic [bpn_pkg::RATIO_W-1:0]   cfg_wdata
);

    localparam int IDX_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

    logic [bpn_pkg::RATIO_W-1:0] clamp_reg;

    logic                        banks_full;
    logic                        wr_en;
    logic [IDX_W:0]              wr_addr;
    logic [bpn_pkg::MAG_W-1:0]   wr_data;
    logic                        push;
    bpn_pkg::desc_t              push_desc;
    logic                        pop;
    bpn_pkg::desc_t              pop_desc;
    logic                        q_not_empty;
    logic                        release_bank;
    logic                        advance;
    logic                        rd_en;
    logic [IDX_W:0]              rd_addr;
    logic [bpn_pkg::MAG_W-1:0]   rd_data;
    logic                        side_valid;
    logic [bpn_pkg::MAG_W-1:0]   side_peak;
    logic                        side_last;
    logic [bpn_pkg::RATIO_W-1:0] ratio;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clamp_reg <= bpn_pkg::LIMIT_RESET;
        else if (cfg_we)
            clamp_reg <= cfg_wdata;
    end

    bpn_front #(
        .MAX_BATCH (MAX_BATCH),
        .IDX_W     (IDX_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .velocity      (s_axis_tdata),
        .last_in_batch (s_axis_tlast),
        .banks_full    (banks_full),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .push          (push),
        .push_desc     (push_desc)
    );

    bpn_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_desc    (push_desc),
        .pop          (pop),
        .pop_desc     (pop_desc),
        .not_empty    (q_not_empty),
        .release_bank (release_bank),
        .banks_full   (banks_full)
    );

    bpn_store #(
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bpn_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_desc       (pop_desc),
        .pop          (pop),
        .release_bank (release_bank),
        .advance      (advance),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .side_valid   (side_valid),
        .side_peak    (side_peak),
        .side_last    (side_last)
    );

    bpn_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (side_valid),
        .in_mag      (rd_data),
        .in_peak     (side_peak),
        .in_last     (side_last),
        .clamp_limit (clamp_reg),
        .advance     (advance),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .ratio       (ratio),
        .last_of_run (m_axis_tlast)
    );

    // result packing
    assign m_axis_tdata = {{(bpn_pkg::OUT_W - bpn_pkg::RATIO_W){1'b0}}, ratio};

endmodule

`default_nettype wire

// File: rtl/bpn_front.sv
// bpn_front: accepts samples, stores magnitudes and tracks batch and running peak
// depends on bpn_pkg; writes into bpn_store and pushes batches into bpn_queue
`default_nettype none

module bpn_front #(
    parameter int MAX_BATCH = 64,
    parameter int IDX_W     = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [bpn_pkg::DATA_W-1:0]  velocity,
    input  wire logic                        last_in_batch,
    input  wire logic                        banks_full,
    output logic                             wr_en,
    output logic [IDX_W:0]                   wr_addr,
    output logic [bpn_pkg::MAG_W-1:0]        wr_data,
    output logic                             push,
    output bpn_pkg::desc_t                   push_desc
);

    logic [bpn_pkg::CNT_W-1:0]  fill_reg;
    logic [bpn_pkg::MAG_W-1:0]  bpeak_reg;
    logic [bpn_pkg::MAG_W-1:0]  rpeak_reg;
    logic                       bank_reg;

    logic                       accept;
    logic [bpn_pkg::DATA_W-1:0] neg_v;
    logic [bpn_pkg::DATA_W-1:0] abs_v;
    logic [bpn_pkg::MAG_W-1:0]  mag;
    logic [bpn_pkg::CNT_W-1:0]  fill_next;
    logic [bpn_pkg::MAG_W-1:0]  bpeak_next;
    logic [bpn_pkg::MAG_W-1:0]  rpeak_next;
    logic                       batch_end;

    assign in_ready = !banks_full;
    assign accept   = in_valid && in_ready;

    // magnitude, most negative sample saturates
    always_comb
    begin
        neg_v = '0 - velocity;
        abs_v = velocity[bpn_pkg::DATA_W-1] ? neg_v : velocity;
        mag   = abs_v[bpn_pkg::DATA_W-1] ? bpn_pkg::MAG_MAX : abs_v[bpn_pkg::MAG_W-1:0];
    end

    // peaks and batch end
    always_comb
    begin
        fill_next  = fill_reg + bpn_pkg::CNT_W'(1);
        bpeak_next = (mag > bpeak_reg) ? mag : bpeak_reg;
        rpeak_next = (bpeak_next > rpeak_reg) ? bpeak_next : rpeak_reg;
        batch_end  = last_in_batch || (fill_next == bpn_pkg::CNT_W'(MAX_BATCH));
    end

    // store write and batch hand-off
    assign wr_en           = accept;
    assign wr_addr         = {bank_reg, fill_reg[IDX_W-1:0]};
    assign wr_data         = mag;
    assign push            = accept && batch_end;
    assign push_desc.bank  = bank_reg;
    assign push_desc.count = fill_next;
    assign push_desc.peak  = rpeak_next;

    // batch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            bpeak_reg <= '0;
            rpeak_reg <= '0;
            bank_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (batch_end)
            begin
                fill_reg  <= '0;
                bpeak_reg <= '0;
                rpeak_reg <= rpeak_next;
                bank_reg  <= !bank_reg;
            end
            else
            begin
                fill_reg  <= fill_next;
                bpeak_reg <= bpeak_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/bpn_queue.sv
// bpn_queue: two-entry queue of finished batches between front and back
// depends on bpn_pkg; also counts batches that still hold a store bank
`default_nettype none

module bpn_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire bpn_pkg::desc_t  push_desc,
    input  wire logic            pop,
    output bpn_pkg::desc_t       pop_desc,
    output logic                 not_empty,
    input  wire logic            release_bank,
    output logic                 banks_full
);

    bpn_pkg::desc_t  entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      pending_reg;

    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign not_empty  = (count_reg != 2'd0);
    assign banks_full = (pending_reg == bpn_pkg::MAX_PENDING);

    // entries
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    // pointers, fill level and banks in use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= 2'd0;
            pending_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
            if (push && !release_bank)
                pending_reg <= pending_reg + 2'd1;
            else if (release_bank && !push)
                pending_reg <= pending_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bpn_store.sv
// bpn_store: two-bank magnitude memory, one write and one registered read per cycle
// depends on bpn_pkg for the magnitude width
`default_nettype none

module bpn_store #(
    parameter int IDX_W = 6
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [IDX_W:0]            wr_addr,
    input  wire logic [bpn_pkg::MAG_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [IDX_W:0]            rd_addr,
    output logic [bpn_pkg::MAG_W-1:0]      rd_data
);

    localparam int DEPTH = 2 ** (IDX_W + 1);

    logic [bpn_pkg::MAG_W-1:0] mem [DEPTH];
    logic [bpn_pkg::MAG_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/bpn_back.sv
// bpn_back: walks a stored batch and issues one store read per cycle while advance is high
// depends on bpn_pkg; feeds bpn_div with the running peak and last mark
`default_nettype none

module bpn_back #(
    parameter int IDX_W = 6
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_not_empty,
    input  wire bpn_pkg::desc_t            q_desc,
    output logic                           pop,
    output logic                           release_bank,
    input  wire logic                      advance,
    output logic                           rd_en,
    output logic [IDX_W:0]                 rd_addr,
    output logic                           side_valid,
    output logic [bpn_pkg::MAG_W-1:0]      side_peak,
    output logic                           side_last
);

    logic                       cur_valid_reg;
    bpn_pkg::desc_t             cur_reg;
    logic [bpn_pkg::CNT_W-1:0]  idx_reg;
    logic                       side_valid_reg;
    logic [bpn_pkg::MAG_W-1:0]  side_peak_reg;
    logic                       side_last_reg;

    logic                       issue;
    logic                       last_issue;
    logic [bpn_pkg::CNT_W-1:0]  idx_next;

    assign pop          = !cur_valid_reg && q_not_empty;
    assign issue        = cur_valid_reg && advance;
    assign idx_next     = idx_reg + bpn_pkg::CNT_W'(1);
    assign last_issue   = (idx_next == cur_reg.count);
    assign release_bank = issue && last_issue;
    assign rd_en        = issue;
    assign rd_addr      = {cur_reg.bank, idx_reg[IDX_W-1:0]};
    assign side_valid   = side_valid_reg;
    assign side_peak    = side_peak_reg;
    assign side_last    = side_last_reg;

    // batch in service
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (issue)
        begin
            if (last_issue)
                cur_valid_reg <= 1'b0;
            idx_reg <= idx_next;
        end
    end

    // sideband aligned with the store read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_valid_reg <= 1'b0;
        else if (advance)
            side_valid_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_peak_reg <= cur_reg.peak;
            side_last_reg <= last_issue;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bpn_div.sv
// bpn_div: pipelined restoring divider, one quotient bit per stage, plus clamp
// depends on bpn_pkg; holds the output register of the result stream
`default_nettype none

module bpn_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [bpn_pkg::MAG_W-1:0]   in_mag,
    input  wire logic [bpn_pkg::MAG_W-1:0]   in_peak,
    input  wire logic                        in_last,
    input  wire logic [bpn_pkg::RATIO_W-1:0] clamp_limit,
    output logic                             advance,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [bpn_pkg::RATIO_W-1:0]      ratio,
    output logic                             last_of_run
);

    localparam int NSTEP = bpn_pkg::RATIO_W;

    logic                          vld_reg  [NSTEP];
    logic [bpn_pkg::MAG_W-1:0]     rem_reg  [NSTEP];
    logic [bpn_pkg::RATIO_W-1:0]   quo_reg  [NSTEP];
    logic [bpn_pkg::MAG_W-1:0]     peak_reg [NSTEP];
    logic                          lst_reg  [NSTEP];

    logic [bpn_pkg::MAG_W:0]       trial    [NSTEP];
    logic [bpn_pkg::MAG_W:0]       diff     [NSTEP];
    logic                          qbit     [NSTEP];
    logic [bpn_pkg::MAG_W-1:0]     rem_next [NSTEP];
    logic [bpn_pkg::RATIO_W-1:0]   quo_next [NSTEP];

    logic                          out_valid_reg;
    logic [bpn_pkg::RATIO_W-1:0]   ratio_reg;
    logic                          last_reg;
    logic [bpn_pkg::RATIO_W-1:0]   quo_fin;
    logic [bpn_pkg::RATIO_W-1:0]   ratio_next;

    assign advance     = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign ratio       = ratio_reg;
    assign last_of_run = last_reg;

    // first step takes the magnitude, later steps the shifted remainder
    always_comb
    begin
        trial[0]    = {1'b0, in_mag};
        diff[0]     = trial[0] - {1'b0, in_peak};
        qbit[0]     = (trial[0] >= {1'b0, in_peak});
        rem_next[0] = qbit[0] ? diff[0][bpn_pkg::MAG_W-1:0] : trial[0][bpn_pkg::MAG_W-1:0];
        quo_next[0] = bpn_pkg::RATIO_W'(qbit[0]);
        for (int i = 1; i < NSTEP; i++)
        begin
            trial[i]    = {rem_reg[i-1], 1'b0};
            diff[i]     = trial[i] - {1'b0, peak_reg[i-1]};
            qbit[i]     = (trial[i] >= {1'b0, peak_reg[i-1]});
            rem_next[i] = qbit[i] ? diff[i][bpn_pkg::MAG_W-1:0]
                                  : trial[i][bpn_pkg::MAG_W-1:0];
            quo_next[i] = {quo_reg[i-1][bpn_pkg::RATIO_W-2:0], qbit[i]};
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTEP; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NSTEP; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]  <= rem_next[0];
            quo_reg[0]  <= quo_next[0];
            peak_reg[0] <= in_peak;
            lst_reg[0]  <= in_last;
            for (int i = 1; i < NSTEP; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                quo_reg[i]  <= quo_next[i];
                peak_reg[i] <= peak_reg[i-1];
                lst_reg[i]  <= lst_reg[i-1];
            end
        end
    end

    // zero peak and clamp
    always_comb
    begin
        quo_fin = quo_reg[NSTEP-1];
        if (peak_reg[NSTEP-1] == '0)
            ratio_next = '0;
        else if (quo_fin > clamp_limit)
            ratio_next = clamp_limit;
        else
            ratio_next = quo_fin;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= vld_reg[NSTEP-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ratio_reg <= ratio_next;
            last_reg  <= lst_reg[NSTEP-1];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bpn_checker.sv
// bpn_checker: port-level checks of the normalizer's result stream
// depends on bpn_pkg; bound to batch_peak_normalizer_unit below
`default_nettype none

module bpn_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [bpn_pkg::OUT_W-1:0]     m_axis_tdata,
    input  wire logic                          m_axis_tlast,
    input  wire logic                          cfg_we,
    input  wire logic [bpn_pkg::RATIO_W-1:0]   cfg_wdata
);

    logic [bpn_pkg::RATIO_W-1:0] limit_reg;

    // shadow of the clamp register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= bpn_pkg::LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    // a stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result item changed while stalled");

    // ratio never exceeds the clamp
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[bpn_pkg::RATIO_W-1:0] <= limit_reg)
        else $error("ratio above clamp limit");

    // padding bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[bpn_pkg::OUT_W-1:bpn_pkg::RATIO_W] == '0)
        else $error("nonzero padding in result item");

    // no result item in the first cycle after reset
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("result item right after reset");

endmodule

bind batch_peak_normalizer_unit bpn_checker u_bpn_checker (.*);

`default_nettype wire

// File: bench/tb_batch_peak_normalizer_unit.sv
// tb_batch_peak_normalizer_unit: self-checking bench for the batch peak normalizer
// needs rtl/bpn_pkg.sv, rtl/batch_peak_normalizer_unit.sv and the other rtl files; drives both streams,
// predicts every ratio in-bench and compares each output item in order
`timescale 1ns / 100ps

module tb_batch_peak_normalizer_unit;

    localparam int BATCH_LIMIT    = 64;
    localparam int HALF_PERIOD    = 10;
    // longest quiet stretch of a correct run is the settle pause before a
    // register write or a stall burst on either side plus the pipeline;
    // this is many times that
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 30;

    typedef struct packed {
        logic [bpn_pkg::RATIO_W-1:0] ratio;
        logic                        last_of_run;
    } ratio_item_t;

    // dut signals
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [bpn_pkg::DATA_W-1:0]  s_axis_tdata = '0;
    logic                        s_axis_tlast = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [bpn_pkg::OUT_W-1:0]   m_axis_tdata;
    logic                        m_axis_tlast;
    logic                        cfg_we = 1'b0;
    logic [bpn_pkg::RATIO_W-1:0] cfg_wdata = '0;

    // bench state
    ratio_item_t                 pending_ratios[$];
    int                          error_count = 0;
    int                          idle_cycles = 0;
    bit                          steady = 1'b0;

    // in-bench copy of the normalizer state
    logic [bpn_pkg::MAG_W-1:0]   mag_store [BATCH_LIMIT];
    logic [bpn_pkg::MAG_W-1:0]   peak_of_batch = '0;
    logic [bpn_pkg::MAG_W-1:0]   peak_so_far = '0;
    int                          batch_fill = 0;
    logic [bpn_pkg::RATIO_W-1:0] clamp_setting = bpn_pkg::LIMIT_RESET;

    batch_peak_normalizer_unit #(
        .MAX_BATCH (BATCH_LIMIT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // 20 ns clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // magnitude of a Q16.16 sample, the most negative one saturating
    function automatic logic [bpn_pkg::MAG_W-1:0] sample_magnitude(
        input logic [bpn_pkg::DATA_W-1:0] v);
        logic [bpn_pkg::DATA_W-1:0] m;
        m = v[bpn_pkg::DATA_W-1] ? (~v + 1'b1) : v;
        if (m > {1'b0, bpn_pkg::MAG_MAX})
            m = {1'b0, bpn_pkg::MAG_MAX};
        return m[bpn_pkg::MAG_W-1:0];
    endfunction

    // truncated Q1.16 ratio against the running peak, clamped
    function automatic logic [bpn_pkg::RATIO_W-1:0] peak_ratio(
        input logic [bpn_pkg::MAG_W-1:0] mag);
        logic [bpn_pkg::MAG_W+bpn_pkg::FRAC_W-1:0] quotient;
        if (peak_so_far == '0)
            return '0;
        quotient = {mag, {bpn_pkg::FRAC_W{1'b0}}}
                   / {{bpn_pkg::FRAC_W{1'b0}}, peak_so_far};
        if (quotient > {{(bpn_pkg::MAG_W+bpn_pkg::FRAC_W-bpn_pkg::RATIO_W){1'b0}},
                        clamp_setting})
            return clamp_setting;
        return quotient[bpn_pkg::RATIO_W-1:0];
    endfunction

    // store one accepted sample; on batch close queue the batch's ratios
    function automatic void normalize_sample(input logic [bpn_pkg::DATA_W-1:0] v,
                                             input logic last);
        logic [bpn_pkg::MAG_W-1:0] mag;
        ratio_item_t               item;
        mag = sample_magnitude(v);
        mag_store[batch_fill] = mag;
        batch_fill++;
        if (mag > peak_of_batch)
            peak_of_batch = mag;
        if (!last && batch_fill < BATCH_LIMIT)
            return;
        if (peak_of_batch > peak_so_far)
            peak_so_far = peak_of_batch;
        for (int k = 0; k < batch_fill; k++)
        begin
            item.ratio       = peak_ratio(mag_store[k]);
            item.last_of_run = (k == batch_fill - 1);
            pending_ratios.push_back(item);
        end
        batch_fill    = 0;
        peak_of_batch = '0;
    endfunction

    // scoreboard: compare output items, predict from input items, watchdog
    always @(posedge clk)
    begin
        ratio_item_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (cfg_we)
                clamp_setting = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
            begin
                idle_cycles = 0;
                if (pending_ratios.size() == 0)
                begin
                    $error("unexpected output item: ratio %0d last %0b",
                           m_axis_tdata[bpn_pkg::RATIO_W-1:0], m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    want = pending_ratios.pop_front();
                    if (m_axis_tdata[bpn_pkg::RATIO_W-1:0] !== want.ratio)
                    begin
                        $error("ratio: expected %0d, actual %0d",
                               want.ratio, m_axis_tdata[bpn_pkg::RATIO_W-1:0]);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last_of_run, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                idle_cycles = 0;
                normalize_sample(s_axis_tdata, s_axis_tlast);
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("batch_peak_normalizer_unit regression: fail");
                $finish;
            end
        end
    end

    // output side: random stall bursts, none in the steady tail
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall == 0 && !steady && rst_n && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 16);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
                m_axis_tready <= rst_n;
        end
    end

    // offer one sample, optionally after a gap, and hold it until taken
    task automatic send_sample(input logic [bpn_pkg::DATA_W-1:0] v, input logic last,
                               input int gap_pct);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(1, 100) <= gap_pct)
            gap = $urandom_range(1, 16);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // drop valid, let every queued ratio drain and the pipeline settle
    task automatic settle_block;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_ratios.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // clamp_limit write while the block is idle
    task automatic write_clamp(input logic [bpn_pkg::RATIO_W-1:0] limit);
        settle_block();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // sample mix: extremes, small magnitudes, full-range words
    function automatic logic [bpn_pkg::DATA_W-1:0] random_velocity();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0001;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            1, 2:
            begin
                if ($urandom_range(0, 1) == 1)
                    return -$urandom_range(0, 2000);
                return $urandom_range(0, 2000);
            end
            default: return $urandom;
        endcase
    endfunction

    // one batch of random samples, closed by the mark unless told not to
    task automatic send_batch(input int len, input bit close);
        int gap_pct;
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
        for (int i = 0; i < len; i++)
            send_sample(random_velocity(), close && (i == len - 1), gap_pct);
    endtask

    // untouched running peak: every ratio is zero
    task automatic test_zero_peak;
        send_sample(32'h0000_0000, 1'b0, 30);
        send_sample(32'h0000_0000, 1'b0, 30);
        send_sample(32'h0000_0000, 1'b1, 30);
        send_sample(32'h0000_0000, 1'b1, 30);
    endtask

    // small peaks; a sample equal to the peak hits the default clamp
    task automatic test_small_peaks;
        send_sample(32'h0000_0003, 1'b0, 30);
        send_sample(32'hFFFF_FFF9, 1'b0, 30);
        send_sample(32'h0000_0005, 1'b1, 30);
        send_sample(32'hFFFF_FFF9, 1'b1, 30);
    endtask

    // field extremes; the running peak saturates here
    task automatic test_field_extremes;
        send_sample(32'h7FFF_FFFF, 1'b0, 30);
        send_sample(32'h0000_0001, 1'b0, 30);
        send_sample(32'hFFFF_FFFF, 1'b0, 30);
        send_sample(32'h0000_0000, 1'b0, 30);
        send_sample(32'h8000_0000, 1'b1, 30);
    endtask

    // clamp at full unity and at zero, most negative sample included
    task automatic test_clamp_extremes;
        write_clamp(bpn_pkg::RATIO_W'(65536));
        send_sample(32'h8000_0000, 1'b1, 30);
        send_sample(32'h7FFF_FFFF, 1'b0, 30);
        send_sample(32'h8000_0001, 1'b0, 30);
        send_sample(32'h4000_0000, 1'b1, 30);
        write_clamp(bpn_pkg::RATIO_W'(0));
        send_sample(32'h4000_0000, 1'b0, 30);
        send_sample(32'h8000_0000, 1'b1, 30);
    endtask

    // a full store with no mark closes the batch by itself
    task automatic test_batch_overflow;
        write_clamp(bpn_pkg::LIMIT_RESET);
        send_batch(BATCH_LIMIT, 1'b0);
        send_sample(32'h0001_0000, 1'b1, 30);
    endtask

    // random batches under several clamp settings
    task automatic test_random_batches;
        logic [bpn_pkg::RATIO_W-1:0] limits [4];
        int                          sent;
        int                          len;
        limits[0] = bpn_pkg::RATIO_W'(32768);
        limits[1] = bpn_pkg::RATIO_W'(1);
        limits[2] = bpn_pkg::RATIO_W'($urandom_range(2, 65535));
        limits[3] = bpn_pkg::RATIO_W'(65536);
        foreach (limits[p])
        begin
            write_clamp(limits[p]);
            sent = 0;
            while (sent < 15)
            begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(20, BATCH_LIMIT);
                else
                    len = $urandom_range(1, 8);
                send_batch(len, (len < BATCH_LIMIT) || ($urandom_range(0, 1) == 1));
                sent += len;
            end
        end
    endtask

    // back-to-back traffic with no input gaps and the output side always ready
    task automatic test_steady_stream;
        int sent;
        int len;
        write_clamp(bpn_pkg::LIMIT_RESET);
        steady = 1'b1;
        sent = 0;
        while (sent < 30)
        begin
            len = $urandom_range(1, 10);
            send_batch(len, 1'b1);
            sent += len;
        end
    endtask

    // test sequence
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_zero_peak();
        test_small_peaks();
        test_field_extremes();
        test_clamp_extremes();
        test_batch_overflow();
        test_random_batches();
        test_steady_stream();
        settle_block();
        if (error_count == 0)
            $display("batch_peak_normalizer_unit regression: pass");
        else
            $display("batch_peak_normalizer_unit regression: fail");
        $finish;
    end

endmodule
